// ===== rtl/mcg_pkg.sv =====
// Shared types and constants for the RGBA8 mip chain generator.
// No dependencies; every other file of the block uses it.
package mcg_pkg;

  localparam int PIXEL_W  = 32;
  localparam int WIDTH_W  = 13;
  localparam int HEIGHT_W = 16;
  localparam int BOFF_W   = WIDTH_W + 1;
  localparam int LEVEL_W  = 4;
  localparam int CHAIN_W  = 29;
  localparam int SUM_W    = 10;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_LEVELS = 16;

  localparam int QDEPTH = 4;

  // Register indexes, decoded from paddr[2].
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Geometry of one downsampling step, from level k to level k+1.
  typedef struct packed {
    logic [WIDTH_W-1:0]  pw;
    logic [HEIGHT_W-1:0] ph;
    logic [WIDTH_W-1:0]  nw;
    logic [HEIGHT_W-1:0] nh;
    logic [BOFF_W-1:0]   boff;
    logic [CHAIN_W-1:0]  start;
    logic [CHAIN_W-1:0]  size;
  } geom_entry_t;

endpackage

// ===== rtl/mcg_front.sv =====
// Front part of the mip chain generator: a short queue of base pixels.
// Depends on mcg_pkg.
module mcg_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [mcg_pkg::PIXEL_W-1:0] in_pixel,
  output logic                       q_valid,
  output logic [mcg_pkg::PIXEL_W-1:0] q_pixel,
  input  logic                       q_pop
);
  import mcg_pkg::*;

  localparam int PTR_W = $clog2(QDEPTH);

  logic [PIXEL_W-1:0] buf_mem [QDEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [PTR_W:0]     count;
  logic               push;
  logic               pop;

  assign in_stall = (count == (PTR_W+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_pixel  = buf_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_mem[wr_ptr] <= in_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/mcg_geom.sv =====
// Level geometry table of the mip chain generator, rebuilt one level per
// cycle after reset or a register write. Depends on mcg_pkg.
module mcg_geom #(
  parameter int MAX_WIDTH  = mcg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_LEVELS = mcg_pkg::DEF_MAX_LEVELS,
  localparam int LVL_W     = $clog2(MAX_LEVELS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         restart,
  input  logic [mcg_pkg::WIDTH_W-1:0]  image_width,
  input  logic [mcg_pkg::HEIGHT_W-1:0] image_height,
  input  logic [LVL_W-1:0]             rd_idx,
  output mcg_pkg::geom_entry_t         entry,
  output logic [LVL_W-1:0]             gen_levels,
  output logic                         ready
);
  import mcg_pkg::*;

  localparam logic [1:0] G_INIT = 2'd0;
  localparam logic [1:0] G_RUN  = 2'd1;
  localparam logic [1:0] G_DONE = 2'd2;

  logic [1:0]          gstate;
  logic [WIDTH_W-1:0]  w;
  logic [HEIGHT_W-1:0] h;
  logic [CHAIN_W-1:0]  acc;
  logic [BOFF_W-1:0]   boff;
  logic [LVL_W-1:0]    j;
  geom_entry_t         tbl [MAX_LEVELS];

  logic [WIDTH_W-1:0]  w0;
  logic [HEIGHT_W-1:0] h0;
  logic [WIDTH_W-1:0]  nw;
  logic [HEIGHT_W-1:0] nh;
  logic [WIDTH_W-1:0]  mul_a;
  logic [HEIGHT_W-1:0] mul_b;
  logic [CHAIN_W-1:0]  prod;
  logic                more;

  always_comb begin
    if (image_width == '0) begin
      w0 = WIDTH_W'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w0 = WIDTH_W'(MAX_WIDTH);
    end else begin
      w0 = image_width;
    end
    h0 = (image_height == '0) ? HEIGHT_W'(1) : image_height;
    nw = (w > WIDTH_W'(1)) ? (w >> 1) : WIDTH_W'(1);
    nh = (h > HEIGHT_W'(1)) ? (h >> 1) : HEIGHT_W'(1);
    mul_a = (gstate == G_INIT) ? w0 : nw;
    mul_b = (gstate == G_INIT) ? h0 : nh;
    prod  = CHAIN_W'(mul_a * mul_b);
    more  = (w > WIDTH_W'(1) || h > HEIGHT_W'(1)) && (32'(j) + 1 < MAX_LEVELS);
  end

  assign ready = (gstate == G_DONE);
  assign entry = tbl[rd_idx];

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      gstate     <= G_INIT;
      j          <= '0;
      gen_levels <= '0;
    end else begin
      unique case (gstate)
        G_INIT: begin
          j      <= '0;
          gstate <= G_RUN;
        end
        G_RUN: begin
          if (more) begin
            j <= j + 1'b1;
          end else begin
            gen_levels <= j;
            gstate     <= G_DONE;
          end
        end
        default: begin
          gstate <= G_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (gstate == G_INIT) begin
      w    <= w0;
      h    <= h0;
      acc  <= prod;
      boff <= '0;
    end else if (gstate == G_RUN && more) begin
      tbl[j] <= '{pw: w, ph: h, nw: nw, nh: nh, boff: boff, start: acc, size: prod};
      acc    <= acc + prod;
      boff   <= boff + BOFF_W'(nw);
      w      <= nw;
      h      <= nh;
    end
  end

endmodule

// ===== rtl/mcg_back.sv =====
// Back part of the mip chain generator: walks one pixel up the levels, one
// level per step, with the row pair buffer and the output register.
// Depends on mcg_pkg.
module mcg_back #(
  parameter int MAX_WIDTH  = mcg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_LEVELS = mcg_pkg::DEF_MAX_LEVELS,
  localparam int LVL_W     = $clog2(MAX_LEVELS)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         restart,
  input  logic                         q_valid,
  input  logic [mcg_pkg::PIXEL_W-1:0]  q_pixel,
  output logic                         q_pop,
  input  logic                         geom_ready,
  input  logic [LVL_W-1:0]             gen_levels,
  input  mcg_pkg::geom_entry_t         entry,
  output logic [LVL_W-1:0]             rd_idx,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mcg_pkg::PIXEL_W-1:0]  out_pixel,
  output logic [mcg_pkg::LEVEL_W-1:0]  mip_level,
  output logic [mcg_pkg::CHAIN_W-1:0]  chain_index,
  output logic                         run_last,
  output logic                         chain_done
);
  import mcg_pkg::*;

  localparam int BUF_DEPTH = MAX_WIDTH + MAX_LEVELS;
  localparam int ADDR_W    = $clog2(BUF_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_A    = 2'd1;
  localparam logic [1:0] S_B    = 2'd2;

  localparam logic [1:0] ACT_STOP = 2'd0;
  localparam logic [1:0] ACT_PROD = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // Per-level filter state.
  logic [PIXEL_W-1:0]  pend_r [MAX_LEVELS];
  logic [WIDTH_W-1:0]  col_r  [MAX_LEVELS];
  logic [HEIGHT_W-1:0] row_r  [MAX_LEVELS];
  logic [CHAIN_W-1:0]  nidx_r [MAX_LEVELS];

  logic [4*SUM_W-1:0]  row_mem [BUF_DEPTH];
  logic [4*SUM_W-1:0]  rd_data;

  logic [1:0]          state;
  logic [LVL_W-1:0]    k;
  logic [PIXEL_W-1:0]  cur;
  logic [35:0]         hs_r;
  logic                hc2_r;

  logic                hv;
  logic [PIXEL_W-1:0]  hold_pixel;
  logic [LEVEL_W-1:0]  hold_level;
  logic [CHAIN_W-1:0]  hold_index;
  logic                hold_done;

  logic [WIDTH_W-1:0]  x;
  logic [HEIGHT_W-1:0] y;
  logic [PIXEL_W-1:0]  pend;
  logic [CHAIN_W-1:0]  cnt;
  logic                at_end;
  logic                pw1;
  logic                ph1;
  logic                x_out;
  logic                y_out;
  logic                h_brk;
  logic                h_even;
  logic                v_brk;
  logic                v_even;
  logic [WIDTH_W-1:0]  hcol;
  logic [31:0]         idx32;
  logic [ADDR_W-1:0]   addr;
  logic [35:0]         hs_a;
  logic [4*SUM_W-1:0]  wr_data;
  logic [1:0]          act;
  logic                x_last;
  logic                y_last;
  logic [1:0]          sh;
  logic [10:0]         sum [4];
  logic [10:0]         rnd;
  logic [PIXEL_W-1:0]  res;
  logic [CHAIN_W-1:0]  nidx_inc;
  logic                wrap;
  logic                go;
  logic                out_take;
  logic                do_stop;
  logic                do_prod;
  logic                do_read;

  assign rd_idx   = k;
  assign out_take = out_valid && !out_stall;
  assign go       = !hv || !out_valid || !out_stall;

  always_comb begin
    x      = col_r[k];
    y      = row_r[k];
    pend   = pend_r[k];
    cnt    = nidx_r[k];
    at_end = (k == gen_levels);
    pw1    = (entry.pw == WIDTH_W'(1));
    ph1    = (entry.ph == HEIGHT_W'(1));
    x_out  = ({1'b0, x} >= {entry.nw, 1'b0});
    y_out  = ({1'b0, y} >= {entry.nh, 1'b0});
    for (int ch = 0; ch < 4; ch++) begin
      if (pw1) begin
        hs_a[ch*9 +: 9] = {1'b0, cur[ch*8 +: 8]};
      end else begin
        hs_a[ch*9 +: 9] = {1'b0, pend[ch*8 +: 8]} + {1'b0, cur[ch*8 +: 8]};
      end
      wr_data[ch*SUM_W +: SUM_W] = SUM_W'(hs_a[ch*9 +: 9]);
    end
    hcol   = pw1 ? '0 : (x >> 1);
    idx32  = 32'(entry.boff) + 32'(hcol);
    addr   = idx32[ADDR_W-1:0];
    h_brk  = !pw1 && (x_out || !x[0]);
    h_even = !pw1 && !x_out && !x[0];
    v_brk  = !ph1 && (y_out || idx32 >= 32'(BUF_DEPTH) || !y[0]);
    v_even = !ph1 && !y_out && !(idx32 >= 32'(BUF_DEPTH)) && !y[0];
    if (at_end || h_brk || v_brk) begin
      act = ACT_STOP;
    end else if (ph1) begin
      act = ACT_PROD;
    end else begin
      act = ACT_READ;
    end
    x_last = (32'(x) + 1 >= 32'(entry.pw));
    y_last = (32'(y) + 1 >= 32'(entry.ph));

    // Rounded average: the sample count is 1, 2 or 4, so it is a shift.
    for (int ch = 0; ch < 4; ch++) begin
      if (state == S_B) begin
        sum[ch] = 11'(rd_data[ch*SUM_W +: SUM_W]) + 11'(hs_r[ch*9 +: 9]);
      end else begin
        sum[ch] = 11'(hs_a[ch*9 +: 9]);
      end
    end
    if (state == S_B) begin
      sh = hc2_r ? 2'd2 : 2'd1;
    end else begin
      sh = pw1 ? 2'd0 : 2'd1;
    end
    rnd = (sh == 2'd2) ? 11'd2 : ((sh == 2'd1) ? 11'd1 : 11'd0);
    for (int ch = 0; ch < 4; ch++) begin
      res[ch*8 +: 8] = 8'((sum[ch] + rnd) >> sh);
    end
    nidx_inc = cnt + 1'b1;
    wrap     = (nidx_inc >= entry.size);

    do_stop = (state == S_A) && go && (act == ACT_STOP);
    do_read = (state == S_A) && go && (act == ACT_READ);
    do_prod = go && (((state == S_A) && (act == ACT_PROD)) || (state == S_B));
    q_pop   = (state == S_IDLE) && q_valid && geom_ready;
  end

  always_ff @(posedge clk) begin
    if ((state == S_A) && go && !at_end && !h_brk && v_even) begin
      row_mem[addr] <= wr_data;
    end
    if (do_read) begin
      rd_data <= row_mem[addr];
    end
  end

  // Per-level counters and pending pixels.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        pend_r[i] <= '0;
        col_r[i]  <= '0;
        row_r[i]  <= '0;
        nidx_r[i] <= '0;
      end
    end else begin
      if ((state == S_A) && go && !at_end) begin
        if (x_last) begin
          col_r[k] <= '0;
          row_r[k] <= y_last ? '0 : (y + 1'b1);
        end else begin
          col_r[k] <= x + 1'b1;
        end
        if (h_even) begin
          pend_r[k] <= cur;
        end
      end
      if (do_prod) begin
        nidx_r[k] <= wrap ? '0 : nidx_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      hv        <= 1'b0;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      if ((do_stop || do_prod) && hv) begin
        out_valid <= 1'b1;
      end else if (out_take) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            k     <= '0;
            state <= S_A;
          end
        end
        S_A: begin
          if (do_stop) begin
            hv    <= 1'b0;
            state <= S_IDLE;
          end else if (do_read) begin
            state <= S_B;
          end else if (do_prod) begin
            hv    <= 1'b1;
            k     <= k + 1'b1;
          end
        end
        S_B: begin
          if (do_prod) begin
            hv    <= 1'b1;
            k     <= k + 1'b1;
            state <= S_A;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_pixel;
    end
    if (do_read) begin
      hs_r  <= hs_a;
      hc2_r <= !pw1;
    end
    if ((do_stop || do_prod) && hv) begin
      out_pixel   <= hold_pixel;
      mip_level   <= hold_level;
      chain_index <= hold_index;
      chain_done  <= hold_done;
      run_last    <= do_stop;
    end
    if (do_prod) begin
      cur        <= res;
      hold_pixel <= res;
      hold_level <= LEVEL_W'(32'(k) + 1);
      hold_index <= entry.start + cnt;
      hold_done  <= (32'(k) + 1 == 32'(gen_levels)) && wrap;
    end
  end

endmodule

// ===== rtl/rgba8_mip_chain_generator_core.sv =====
// Top level of the RGBA8 mip chain generator: register port, pixel queue,
// geometry table and level engine. Depends on mcg_pkg and the mcg_* modules.
//
// Usage: set image_width (address 0) and image_height (address 4) through the
// APB-style port while the block is idle; each write restarts the chain and
// clears all level counters. Base pixels then enter in raster order on the
// in_valid / in_stall channel, one request per pixel. Every request can
// produce up to fifteen averaged pixels, one per mip level, in increasing
// level order on the out_valid / out_stall channel; run_last marks the last
// result of a request and chain_done the final pixel of the last level.
// Flow: a request leaves the input queue when the engine is idle, then takes
// one step per level it reaches, with an extra step for levels that need the
// row pair buffer (its registered read), plus one step to close the run. The
// level engine is the limit; it takes no new request until the run is closed,
// and a four-entry queue in front takes pixels while the engine works.
// After reset or a register write the geometry table is rebuilt one level
// per cycle; queued pixels wait for it. Reset empties the queue and output
// register and sets a 1x1 image, which produces no results. When the receiver
// stalls, the output register holds its result, the engine finishes the level
// at hand and then waits.
module rgba8_mip_chain_generator_core #(
  parameter int MAX_WIDTH  = mcg_pkg::DEF_MAX_WIDTH,
  parameter int MAX_LEVELS = mcg_pkg::DEF_MAX_LEVELS
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [mcg_pkg::PIXEL_W-1:0] in_pixel,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [mcg_pkg::PIXEL_W-1:0] out_pixel,
  output logic [mcg_pkg::LEVEL_W-1:0] mip_level,
  output logic [mcg_pkg::CHAIN_W-1:0] chain_index,
  output logic                        run_last,
  output logic                        chain_done,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import mcg_pkg::*;

  localparam int LVL_W = $clog2(MAX_LEVELS);

  logic [WIDTH_W-1:0]  image_width;
  logic [HEIGHT_W-1:0] image_height;
  logic                wr_en;
  logic                restart;

  logic                q_valid;
  logic [PIXEL_W-1:0]  q_pixel;
  logic                q_pop;

  geom_entry_t         entry;
  logic [LVL_W-1:0]    gen_levels;
  logic [LVL_W-1:0]    rd_idx;
  logic                geom_ready;

  // Register port: any completed write restarts the chain.
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign restart = wr_en;

  always_comb begin
    unique case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = 32'(image_width);
      REG_IMAGE_HEIGHT: prdata = 32'(image_height);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_W'(1);
      image_height <= HEIGHT_W'(1);
    end else if (wr_en) begin
      if (paddr[2] == REG_IMAGE_WIDTH) begin
        image_width <= pwdata[WIDTH_W-1:0];
      end else begin
        image_height <= pwdata[HEIGHT_W-1:0];
      end
    end
  end

  mcg_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_pixel (in_pixel),
    .q_valid  (q_valid),
    .q_pixel  (q_pixel),
    .q_pop    (q_pop)
  );

  mcg_geom #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_geom (
    .clk          (clk),
    .rst          (rst),
    .restart      (restart),
    .image_width  (image_width),
    .image_height (image_height),
    .rd_idx       (rd_idx),
    .entry        (entry),
    .gen_levels   (gen_levels),
    .ready        (geom_ready)
  );

  mcg_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .restart     (restart),
    .q_valid     (q_valid),
    .q_pixel     (q_pixel),
    .q_pop       (q_pop),
    .geom_ready  (geom_ready),
    .gen_levels  (gen_levels),
    .entry       (entry),
    .rd_idx      (rd_idx),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_pixel   (out_pixel),
    .mip_level   (mip_level),
    .chain_index (chain_index),
    .run_last    (run_last),
    .chain_done  (chain_done)
  );

endmodule

// ===== rtl/mcg_checker.sv =====
// Port-level checks for the mip chain generator, bound to the top level.
// Depends on mcg_pkg for field widths.
module mcg_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [mcg_pkg::PIXEL_W-1:0] out_pixel,
  input logic [mcg_pkg::LEVEL_W-1:0] mip_level,
  input logic [mcg_pkg::CHAIN_W-1:0] chain_index,
  input logic                        run_last,
  input logic                        chain_done
);

  // The last pixel of the chain is on the top level, so it closes its run.
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && chain_done |-> run_last)
    else $error("chain_done without run_last");

  // Results only exist for levels above the base.
  a_level_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mip_level != '0)
    else $error("result on base level");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(out_pixel) && $stable(chain_index)
      && $stable(mip_level) && $stable(run_last) && $stable(chain_done))
    else $error("stalled result changed");

endmodule

bind rgba8_mip_chain_generator_core mcg_checker u_mcg_checker (.*);
